### hw/rtl/cyclic_code_parity_encoder_checker_macros.svh
// Assertion macros for the cyclic code parity encoder and checker.
`ifndef CYCLIC_CODE_PARITY_ENCODER_CHECKER_MACROS_SVH
`define CYCLIC_CODE_PARITY_ENCODER_CHECKER_MACROS_SVH

// Same-cycle implication, clocked on clk_i, off while rst_ni is low.
`define CCPE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off while rst_ni is low.
`define CCPE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/ccpe_pkg.sv
// Types and constants shared by the cyclic code parity encoder and checker.
`timescale 1ns / 1ps
package ccpe_pkg;

  localparam int DLEN_W      = 12;
  localparam int PLEN_W      = 6;
  localparam int TAP_W       = 32;
  localparam int POS_W       = 13;
  localparam int CLEN_W      = 18;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DATA_LEN    = 3'd0,
    CFG_PARITY_LEN  = 3'd1,
    CFG_GEN_TAPS    = 3'd2,
    CFG_INIT_PARITY = 3'd3,
    CFG_MODE        = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    MODE_ENCODE = 1'b0,
    MODE_CHECK  = 1'b1
  } mode_e;

  typedef struct packed {
    logic [DLEN_W-1:0] data_len;
    logic [PLEN_W-1:0] parity_len;
    logic [TAP_W-1:0]  gen_taps;
    logic [TAP_W-1:0]  init_parity;
    mode_e             mode;
  } cfg_t;

  localparam logic [DLEN_W-1:0] DATA_LEN_RST    = 12'd7;
  localparam logic [PLEN_W-1:0] PARITY_LEN_RST  = 6'd8;
  localparam logic [TAP_W-1:0]  GEN_TAPS_RST    = 32'd209;
  localparam logic [TAP_W-1:0]  INIT_PARITY_RST = 32'd0;

  // One result item.
  typedef struct packed {
    logic out_bit;
    logic is_parity;
    logic last;
  } res_t;

  // Queue entry: a single result, or a data bit followed by a parity burst.
  typedef struct packed {
    res_t              res;
    logic              burst;
    logic [PLEN_W-1:0] plen;
  } cmd_t;

endpackage

### hw/rtl/ccpe_in_if.sv
// Request channel carrying one code bit per request.
`timescale 1ns / 1ps
interface ccpe_in_if;
  logic valid;
  logic ready;
  logic code_bit;

  modport source (output valid, output code_bit, input ready);
  modport sink (input valid, input code_bit, output ready);
endinterface

### hw/rtl/ccpe_out_if.sv
// Result channel carrying one output bit with its flags.
`timescale 1ns / 1ps
interface ccpe_out_if;
  logic valid;
  logic ready;
  logic out_bit;
  logic is_parity;
  logic last;

  modport source (output valid, output out_bit, output is_parity, output last, input ready);
  modport sink (input valid, input out_bit, input is_parity, input last, output ready);
endinterface

### hw/rtl/ccpe_fifo.sv
// Short register queue between the front and back parts.
`timescale 1ns / 1ps
module ccpe_fifo import ccpe_pkg::*; #(
  parameter int W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] wdata_i,
  input  logic         pop_i,
  output logic [W-1:0] rdata_o,
  output logic         full_o,
  output logic         empty_o
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [W-1:0]  mem_q [QUEUE_DEPTH];
  logic [AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CW'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + AW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + AW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

### hw/rtl/ccpe_front.sv
// Front part: accepts code bits, runs the division register and classifies results.
`timescale 1ns / 1ps
module ccpe_front import ccpe_pkg::*; #(
  parameter int MAX_PARITY   = 32,
  parameter int MAX_CODE_LEN = 4096
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cfg_t                  cfg_i,
  input  logic                  in_valid_i,
  input  logic                  in_bit_i,
  output logic                  in_ready_o,
  input  logic                  full_i,
  output logic                  push_o,
  output cmd_t                  cmd_o,
  output logic [MAX_PARITY-1:0] par_o
);

  localparam int PW = $clog2(MAX_PARITY + 1);
  localparam int TE = 2 ** PW;
  localparam int RI = $clog2(MAX_PARITY);
  localparam int PX = POS_W + 1;

  logic [MAX_PARITY-1:0] rem_q, rem_d, rem_div, mask, init_ext;
  logic [POS_W-1:0]      pos_q, pos_d, t_off;
  logic [PW-1:0]         p_eff, j;
  logic [DLEN_W-1:0]     k0, k_eff;
  logic [CLEN_W-1:0]     len_sum, len_lim;
  logic [TE-1:0]         taps_ext;
  logic                  fb, rbit, data_phase, final_data, final_chk;

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;
  assign taps_ext   = TE'(cfg_i.gen_taps);
  assign init_ext   = MAX_PARITY'(cfg_i.init_parity);

  // Effective lengths after clamping.
  always_comb begin
    p_eff   = (cfg_i.parity_len > PLEN_W'(MAX_PARITY)) ? PW'(MAX_PARITY)
                                                       : PW'(cfg_i.parity_len);
    k0      = (cfg_i.data_len == '0) ? DLEN_W'(1) : cfg_i.data_len;
    len_sum = CLEN_W'(k0) + CLEN_W'(p_eff);
    len_lim = CLEN_W'(MAX_CODE_LEN) - CLEN_W'(p_eff);
    k_eff   = k0;
    if (len_sum > CLEN_W'(MAX_CODE_LEN)) begin
      if (CLEN_W'(MAX_CODE_LEN) > CLEN_W'(p_eff) + CLEN_W'(1)) begin
        k_eff = len_lim[DLEN_W-1:0];
      end else begin
        k_eff = DLEN_W'(1);
      end
    end
  end

  // Feedback mask: remainder bit t takes generator tap p-1-t.
  always_comb begin
    j    = '0;
    mask = '0;
    for (int t = 0; t < MAX_PARITY; t++) begin
      if (PW'(t) < p_eff) begin
        j       = p_eff - PW'(t) - PW'(1);
        mask[t] = taps_ext[j];
      end
    end
  end

  always_comb begin
    fb         = in_bit_i ^ rem_q[0];
    rem_div    = (rem_q >> 1) ^ (fb ? mask : '0);
    data_phase = (cfg_i.mode == MODE_ENCODE) || (pos_q < POS_W'(k_eff));
    final_data = (pos_q + POS_W'(1)) >= POS_W'(k_eff);
    t_off      = pos_q - POS_W'(k_eff);
    rbit       = (t_off < POS_W'(MAX_PARITY)) ? rem_q[t_off[RI-1:0]] : 1'b0;
    final_chk  = (PX'(t_off) + PX'(1)) >= PX'(p_eff);
  end

  always_comb begin
    cmd_o = '0;
    par_o = init_ext ^ rem_div;
    rem_d = rem_q;
    pos_d = pos_q;
    if (data_phase) begin
      cmd_o.res.out_bit = in_bit_i;
      rem_d             = rem_div;
      if (!final_data) begin
        pos_d = pos_q + POS_W'(1);
      end else if (cfg_i.mode == MODE_ENCODE) begin
        // Last data bit: hand the whole parity word to the back part.
        cmd_o.burst    = 1'b1;
        cmd_o.plen     = PLEN_W'(p_eff);
        cmd_o.res.last = (p_eff == '0);
        rem_d          = '0;
        pos_d          = '0;
      end else begin
        cmd_o.res.last = (p_eff == '0);
        if (p_eff == '0) begin
          rem_d = '0;
          pos_d = '0;
        end else begin
          pos_d = pos_q + POS_W'(1);
        end
      end
    end else begin
      // Syndrome bit.
      cmd_o.res.out_bit   = in_bit_i ^ rbit;
      cmd_o.res.is_parity = 1'b1;
      cmd_o.res.last      = final_chk;
      if (final_chk) begin
        rem_d = '0;
        pos_d = '0;
      end else begin
        pos_d = pos_q + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      pos_q <= '0;
    end else if (push_o) begin
      rem_q <= rem_d;
      pos_q <= pos_d;
    end
  end

endmodule

### hw/rtl/ccpe_back.sv
// Back part: drains the queue and plays parity bursts one bit per unstalled cycle.
`timescale 1ns / 1ps
module ccpe_back import ccpe_pkg::*; #(
  parameter int MAX_PARITY = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  cmd_t                  q_cmd_i,
  input  logic [MAX_PARITY-1:0] q_par_i,
  output logic                  q_pop_o,
  output logic                  busy_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output res_t                  out_res_o
);

  logic                  out_valid_q, out_valid_d;
  res_t                  out_res_q, out_res_d;
  logic [MAX_PARITY-1:0] par_q, par_d;
  logic [PLEN_W-1:0]     left_q, left_d;
  logic                  load;

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;
  assign busy_o      = (left_q != '0);
  assign load        = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    par_d       = par_q;
    left_d      = left_q;
    q_pop_o     = 1'b0;
    if (load) begin
      if (left_q != '0) begin
        out_valid_d         = 1'b1;
        out_res_d.out_bit   = par_q[0];
        out_res_d.is_parity = 1'b1;
        out_res_d.last      = (left_q == PLEN_W'(1));
        par_d               = par_q >> 1;
        left_d              = left_q - PLEN_W'(1);
      end else if (q_valid_i) begin
        q_pop_o     = 1'b1;
        out_valid_d = 1'b1;
        out_res_d   = q_cmd_i.res;
        if (q_cmd_i.burst) begin
          par_d  = q_par_i;
          left_d = q_cmd_i.plen;
        end
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      left_q      <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      left_q      <= left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q <= out_res_d;
    par_q     <= par_d;
  end

endmodule

### hw/rtl/cyclic_code_parity_encoder_checker.sv
// Top level of the serial cyclic code parity encoder and checker.
// Usage:
//   req_i carries one code bit per request. Each codeword starts with data_len
//   data bits; in check mode parity_len received parity bits follow.
//   res_o returns one bit per result with is_parity and last flags. Data bits
//   are echoed; in encode mode the last data bit is followed by parity_len
//   parity bits, in check mode each received parity bit comes back as a
//   syndrome bit (all zero for a valid codeword).
//   Configuration: write cfg_wdata_i to register cfg_idx_i while cfg_we_i is
//   high (data_len, parity_len, gen_taps, init_parity, mode). Write only while
//   no results are outstanding.
// Timing:
//   A request's result passes through the queue and the output register before
//   it is offered. One request per cycle is taken while the two-entry queue has
//   room; the final data bit in encode mode is followed on the result port by
//   its parity burst, so requests back up into the queue during that burst.
// Reset: config returns to data_len 7, parity_len 8, taps 0xD1, encode mode;
//   the remainder, bit position, queue and output valid flag are cleared.
// Stall: a stalled receiver holds the result; the queue fills, then req_i.ready
//   drops until the receiver takes results again.
`timescale 1ns / 1ps
`include "cyclic_code_parity_encoder_checker_macros.svh"
module cyclic_code_parity_encoder_checker import ccpe_pkg::*; #(
  parameter int MAX_PARITY   = 32,
  parameter int MAX_CODE_LEN = 4096
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  ccpe_in_if.sink               req_i,
  ccpe_out_if.source            res_o
);

  localparam int QW = $bits(cmd_t) + MAX_PARITY;

  cfg_t                  cfg_q;
  cmd_t                  f_cmd, q_cmd;
  logic [MAX_PARITY-1:0] f_par, q_par;
  logic                  q_push, q_pop, q_full, q_empty, bk_busy, res_valid;
  logic                  burst_pop;
  res_t                  res;

  // Configuration registers; writes to unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.data_len    <= DATA_LEN_RST;
      cfg_q.parity_len  <= PARITY_LEN_RST;
      cfg_q.gen_taps    <= GEN_TAPS_RST;
      cfg_q.init_parity <= INIT_PARITY_RST;
      cfg_q.mode        <= MODE_ENCODE;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_DATA_LEN:    cfg_q.data_len    <= cfg_wdata_i[DLEN_W-1:0];
        CFG_PARITY_LEN:  cfg_q.parity_len  <= cfg_wdata_i[PLEN_W-1:0];
        CFG_GEN_TAPS:    cfg_q.gen_taps    <= cfg_wdata_i[TAP_W-1:0];
        CFG_INIT_PARITY: cfg_q.init_parity <= cfg_wdata_i[TAP_W-1:0];
        CFG_MODE:        cfg_q.mode        <= mode_e'(cfg_wdata_i[0]);
        default: begin
        end
      endcase
    end
  end

  // Front: division register and result classification.
  ccpe_front #(
    .MAX_PARITY  (MAX_PARITY),
    .MAX_CODE_LEN(MAX_CODE_LEN)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .in_valid_i(req_i.valid),
    .in_bit_i  (req_i.code_bit),
    .in_ready_o(req_i.ready),
    .full_i    (q_full),
    .push_o    (q_push),
    .cmd_o     (f_cmd),
    .par_o     (f_par)
  );

  // Queue decouples the front from bursts and stalls on the result side.
  ccpe_fifo #(
    .W(QW)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .wdata_i({f_cmd, f_par}),
    .pop_i  (q_pop),
    .rdata_o({q_cmd, q_par}),
    .full_o (q_full),
    .empty_o(q_empty)
  );

  // Back: output register and parity burst sequencing.
  ccpe_back #(
    .MAX_PARITY(MAX_PARITY)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (!q_empty),
    .q_cmd_i    (q_cmd),
    .q_par_i    (q_par),
    .q_pop_o    (q_pop),
    .busy_o     (bk_busy),
    .out_valid_o(res_valid),
    .out_ready_i(res_o.ready),
    .out_res_o  (res)
  );

  assign res_o.valid     = res_valid;
  assign res_o.out_bit   = res.out_bit;
  assign res_o.is_parity = res.is_parity;
  assign res_o.last      = res.last;

  // A popped burst with parity bits must start the playout.
  assign burst_pop = q_pop && q_cmd.burst && (q_cmd.plen != '0);

  `CCPE_ASSERT_NOW(a_pop_not_empty, q_pop, !q_empty, "queue popped while empty")
  `CCPE_ASSERT_NOW(a_no_pop_in_burst, bk_busy, !q_pop, "queue popped during parity burst")
  `CCPE_ASSERT_NEXT(a_burst_starts, burst_pop, bk_busy, "parity burst did not start")

endmodule

### tb/tb_cyclic_code_parity_encoder_checker.sv
// Self-checking testbench for the serial cyclic code parity encoder and checker.
`timescale 1ns / 1ps
module tb_cyclic_code_parity_encoder_checker;
  import ccpe_pkg::*;

  localparam int MAX_PARITY   = 32;
  localparam int MAX_CODE_LEN = 4096;
  localparam int RANDOM_BITS  = 360;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int HOLD_CYCLES  = 150;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  ccpe_in_if req_if ();
  ccpe_out_if res_if ();

  cyclic_code_parity_encoder_checker dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .req_i      (req_if),
    .res_o      (res_if)
  );

  always #2 clk = ~clk;

  // Shadow copy of the register file, updated on each write.
  logic [DLEN_W-1:0] cfg_dlen = DATA_LEN_RST;
  logic [PLEN_W-1:0] cfg_plen = PARITY_LEN_RST;
  logic [TAP_W-1:0]  cfg_taps = GEN_TAPS_RST;
  logic [TAP_W-1:0]  cfg_init = INIT_PARITY_RST;
  mode_e             cfg_mode = MODE_ENCODE;

  // Division state of the codeword in progress.
  logic [MAX_PARITY-1:0] rem_bits = '0;
  int unsigned           word_pos = 0;

  logic pend_q[$];    // code bits not yet offered
  res_t owed_q[$];    // results the block still owes, oldest first
  int   sent_bits = 0;
  int   err_cnt = 0;
  int   res_cnt = 0;
  int   hold_left = 0;
  bit   squeezed = 1'b0;
  logic squeeze = 1'b0;  // ask the receiver for one long hold-off
  logic calm = 1'b0;     // no random gaps on either side while set
  int unsigned cycle_cnt = 0;

  // Append one owed result.
  task automatic owe(input logic b, input logic par, input logic lst);
    res_t r;
    r.out_bit   = b;
    r.is_parity = par;
    r.last      = lst;
    owed_q = {owed_q, r};
  endtask

  // Append one code bit to the pending requests.
  task automatic queue_bit(input logic b);
    pend_q = {pend_q, b};
    sent_bits++;
  endtask

  // Divide one accepted bit through the remainder register and queue the
  // results it produces. Lengths are clamped the same way the block does.
  task automatic divide_and_emit(input logic din);
    int unsigned p, k, t, par_idx;
    logic fb, rbit;
    bit fin;
    p = (cfg_plen > MAX_PARITY) ? MAX_PARITY : cfg_plen;
    k = (cfg_dlen == 0) ? 1 : cfg_dlen;
    if (k + p > MAX_CODE_LEN) k = (MAX_CODE_LEN > p + 1) ? MAX_CODE_LEN - p : 1;
    if (cfg_mode == MODE_ENCODE || word_pos < k) begin
      fb = din ^ rem_bits[0];
      fin = (word_pos + 1 >= k);
      rem_bits = rem_bits >> 1;
      // Tap at exponent e feeds remainder bit p-1-e; taps at or above p drop out.
      if (fb) begin
        for (t = 0; t < p; t++) begin
          if (cfg_taps[p-1-t]) rem_bits[t] = ~rem_bits[t];
        end
      end
      if (!fin) begin
        owe(din, 1'b0, 1'b0);
        word_pos++;
      end else begin
        // With no parity bits the last data bit closes the codeword.
        owe(din, 1'b0, (p == 0));
        if (cfg_mode == MODE_ENCODE) begin
          // Parity burst: all p bits follow the last data bit.
          for (t = 0; t < p; t++) begin
            owe(cfg_init[t] ^ rem_bits[t], 1'b1, (t + 1 == p));
          end
          rem_bits = '0;
          word_pos = 0;
        end else if (p == 0) begin
          rem_bits = '0;
          word_pos = 0;
        end else begin
          word_pos++;
        end
      end
    end else begin
      // Check mode, parity part: syndrome bit. Past the register it reads 0.
      par_idx = word_pos - k;
      rbit = (par_idx < MAX_PARITY) ? rem_bits[par_idx] : 1'b0;
      fin = (par_idx + 1 >= p);
      owe(din ^ rbit, 1'b1, fin);
      if (fin) begin
        rem_bits = '0;
        word_pos = 0;
      end else begin
        word_pos++;
      end
    end
  endtask

  // Request driver: hold an offer until taken, otherwise offer the next bit
  // or idle at random.
  always @(posedge clk) begin
    if (rst_n) begin
      if (req_if.valid && req_if.ready) divide_and_emit(req_if.code_bit);
      if (!req_if.valid || req_if.ready) begin
        if (pend_q.size() != 0 && (calm || $urandom_range(0, 99) >= 8)) begin
          req_if.valid <= 1'b1;
          req_if.code_bit <= pend_q.pop_front();
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each taken result with the oldest one owed, and
  // drive ready with random stalls plus one long hold-off on request.
  always @(posedge clk) begin : watch_results
    res_t want;
    if (rst_n) begin
      if (res_if.valid && res_if.ready) begin
        res_cnt++;
        if (owed_q.size() == 0) begin
          $error("unexpected result: out_bit %0b is_parity %0b last %0b",
                 res_if.out_bit, res_if.is_parity, res_if.last);
          err_cnt++;
        end else begin
          want = owed_q.pop_front();
          if (res_if.out_bit !== want.out_bit) begin
            $error("out_bit: expected %0b, got %0b", want.out_bit, res_if.out_bit);
            err_cnt++;
          end
          if (res_if.is_parity !== want.is_parity) begin
            $error("is_parity: expected %0b, got %0b", want.is_parity, res_if.is_parity);
            err_cnt++;
          end
          if (res_if.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, res_if.last);
            err_cnt++;
          end
        end
      end
      if (squeeze && !squeezed) begin
        hold_left = HOLD_CYCLES;
        squeezed = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= calm || ($urandom_range(0, 99) >= 8);
      end
    end
  end

  // Watchdog: end the run if it hangs.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb_cyclic_code_parity_encoder_checker: FAIL");
      $finish;
    end
  end

  // Write one register and track it in the shadow copy.
  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_DATA_LEN:    cfg_dlen = val[DLEN_W-1:0];
      CFG_PARITY_LEN:  cfg_plen = val[PLEN_W-1:0];
      CFG_GEN_TAPS:    cfg_taps = val[TAP_W-1:0];
      CFG_INIT_PARITY: cfg_init = val[TAP_W-1:0];
      CFG_MODE:        cfg_mode = mode_e'(val[0]);
      default: ;
    endcase
  endtask

  // Queue n code bits, LSB first.
  task automatic push_bits(input logic [63:0] bits, input int n);
    @(negedge clk);
    for (int i = 0; i < n; i++) begin
      queue_bit(bits[i]);
    end
  endtask

  // Hold off until every request is taken and every result is back, then let
  // the pipeline drain.
  task automatic settle();
    while (pend_q.size() != 0 || req_if.valid || owed_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // One random setting followed by a burst of random bits. The bit count is
  // not tied to codeword boundaries, so the next setting often lands
  // mid-codeword.
  task automatic random_phase(input int n_force);
    int r, n;
    r = $urandom_range(0, 99);
    write_reg(CFG_DATA_LEN, (r < 6) ? 0 : (r < 10) ? $urandom_range(13, 4095)
                                                    : $urandom_range(1, 12));
    r = $urandom_range(0, 99);
    write_reg(CFG_PARITY_LEN, (r < 6) ? 0 : (r < 12) ? $urandom_range(33, 63)
                                                      : $urandom_range(1, 32));
    write_reg(CFG_GEN_TAPS, $urandom);
    write_reg(CFG_INIT_PARITY, $urandom);
    write_reg(CFG_MODE, $urandom_range(0, 1));
    n = (n_force > 0) ? n_force : $urandom_range(4, 60);
    @(negedge clk);
    for (int i = 0; i < n; i++) begin
      queue_bit(logic'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    int phase;
    req_if.valid = 1'b0;
    req_if.code_bit = 1'b0;
    res_if.ready = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset setting: encode, 7 data bits, 8 parity bits, taps 0xD1.
    push_bits(64'b1001101, 7);
    settle();

    // Zero data length acts as one; parity length 63 clamps to 32; all taps
    // and all preset parity bits set.
    write_reg(CFG_DATA_LEN, 0);
    write_reg(CFG_PARITY_LEN, 63);
    write_reg(CFG_GEN_TAPS, '1);
    write_reg(CFG_INIT_PARITY, '1);
    push_bits(64'b01, 2);
    settle();

    // Zero parity length in check mode: last rides on the final data bit.
    write_reg(CFG_DATA_LEN, 2);
    write_reg(CFG_PARITY_LEN, 0);
    write_reg(CFG_MODE, MODE_CHECK);
    push_bits(64'b10, 2);
    settle();

    // Only taps at or above the parity length: they must have no effect.
    write_reg(CFG_DATA_LEN, 1);
    write_reg(CFG_PARITY_LEN, 3);
    write_reg(CFG_GEN_TAPS, 32'hFFFF_FFF0);
    write_reg(CFG_INIT_PARITY, 0);
    push_bits(64'b1011, 4);
    settle();

    // Check mode, shrink parity length in the middle of the parity part.
    write_reg(CFG_DATA_LEN, 4);
    write_reg(CFG_PARITY_LEN, 4);
    write_reg(CFG_GEN_TAPS, 32'h13);
    push_bits(64'b10110, 5);
    settle();
    write_reg(CFG_PARITY_LEN, 2);
    push_bits(64'b1, 1);
    settle();

    // Encode mode, shrink data length mid-codeword: next bit ends the data.
    write_reg(CFG_MODE, MODE_ENCODE);
    write_reg(CFG_DATA_LEN, 6);
    push_bits(64'b011, 3);
    settle();
    write_reg(CFG_DATA_LEN, 2);
    push_bits(64'b1, 1);
    settle();

    // Random settings. The first phase gets a long receiver hold-off while
    // the sender keeps offering; a few later phases run without gaps.
    sent_bits = 0;
    phase = 0;
    while (sent_bits < RANDOM_BITS) begin
      if (phase == 4) calm <= 1'b1;
      if (phase == 8) calm <= 1'b0;
      random_phase((phase == 0) ? 80 : 0);
      if (phase == 0) squeeze <= 1'b1;
      settle();
      phase++;
    end
    calm <= 1'b0;

    // Overlong codeword setting: 4095 + 32 exceeds the limit; a few data bits
    // go through well short of the cut length.
    write_reg(CFG_DATA_LEN, 4095);
    write_reg(CFG_PARITY_LEN, 63);
    write_reg(CFG_GEN_TAPS, $urandom);
    write_reg(CFG_INIT_PARITY, $urandom);
    write_reg(CFG_MODE, MODE_ENCODE);
    @(negedge clk);
    for (int i = 0; i < 8; i++) begin
      queue_bit(logic'($urandom_range(0, 1)));
    end
    settle();

    repeat (8) @(negedge clk);
    if (owed_q.size() != 0) begin
      $error("%0d expected results never arrived", owed_q.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("tb_cyclic_code_parity_encoder_checker: PASS");
    end else begin
      $display("tb_cyclic_code_parity_encoder_checker: FAIL");
    end
    $finish;
  end

endmodule

### cyclic_code_parity_encoder_checker.f
+incdir+hw/rtl
hw/rtl/ccpe_pkg.sv
hw/rtl/ccpe_in_if.sv
hw/rtl/ccpe_out_if.sv
hw/rtl/ccpe_fifo.sv
hw/rtl/ccpe_front.sv
hw/rtl/ccpe_back.sv
hw/rtl/cyclic_code_parity_encoder_checker.sv
tb/tb_cyclic_code_parity_encoder_checker.sv
